// ===== rtl/core/parzen_hac_variance_assert.svh =====
// assertion macros shared by the parzen hac variance rtl
`ifndef PARZEN_HAC_VARIANCE_ASSERT_SVH
`define PARZEN_HAC_VARIANCE_ASSERT_SVH

// same-cycle implication under the active-low reset
`define PHV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under the active-low reset
`define PHV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/phv_pkg.sv =====
`default_nettype none

package phv_pkg;

  // fixed field widths
  localparam int LAG_BITS   = 7;
  localparam int ACC_BITS   = 64;
  localparam int WORD_BITS  = 32;
  localparam int CNT_BITS   = 32;

  // weight computation widths (lag never exceeds 127)
  localparam int SQ_BITS    = 14;
  localparam int CUBE_BITS  = 21;
  localparam int NUM_BITS   = 22;
  localparam int WQ_BITS    = 31;
  localparam int DIV_STEPS  = 31;
  localparam int DIV_CNT_BITS = 5;
  localparam int FRAC_BITS  = 30;

  localparam logic [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
  localparam logic [WQ_BITS-1:0]  WQ_ONE  = WQ_BITS'(1) << FRAC_BITS;

  // per-cell control
  typedef struct packed {
    logic load;   // new word shifts into the delay line, product formed
    logic add;    // product accumulates
    logic drain;  // accumulators move one cell toward the head
    logic clear;  // series restart
  } cell_ctl_t;

  typedef struct packed {
    logic [ACC_BITS-1:0] val;
    logic                ovf;
  } sat_res_t;

  typedef enum logic [3:0] {
    ST_RUN,
    ST_SETTLE,
    ST_CHECK,
    ST_WSTART,
    ST_WWAIT,
    ST_MUL,
    ST_TERM,
    ST_ACC,
    ST_DBL,
    ST_SUM,
    ST_DONE
  } top_state_e;

  typedef enum logic [2:0] {
    WS_IDLE,
    WS_SQ,
    WS_CUBE,
    WS_NUM,
    WS_DIV,
    WS_DONE
  } wgt_state_e;

  // signed 64-bit add that clamps to the int64 range
  function automatic sat_res_t sat_add(logic [ACC_BITS-1:0] a, logic [ACC_BITS-1:0] b);
    logic [ACC_BITS:0] sum;
    sat_res_t          res;
    sum = {a[ACC_BITS-1], a} + {b[ACC_BITS-1], b};
    if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
      res.ovf = 1'b1;
      res.val = sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
    end else begin
      res.ovf = 1'b0;
      res.val = sum[ACC_BITS-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/parzen_hac_variance.sv =====
// Parzen-kernel HAC long-run variance of a streamed Q1.30 series.
// Input channel (in_valid_i/in_ready_o) carries one word per sample with
// sample_i and last_i. Output channel (out_valid_o/out_ready_i) carries one
// result word per series: variance_o (Q3.60), too_few_o, saturated_o.
// The lag register is written through cfg_we_i/cfg_wdata_i; reset value 2.
// A row of MAX_LAG cells holds the delay line and one accumulator per lag;
// every cell multiplies the incoming sample with its tap in the same cycle,
// so samples that are not last are taken one per clock cycle.
// On the last sample the accumulators are streamed out of the cell row
// toward its head, one lag per term. Each term needs a Parzen weight from
// a 31-step restoring divider. A series takes L terms (L = effective lag);
// with too few samples or a lag of 0 or 1 no term is formed and the
// result is written without the weighting pass. No sample
// is taken during that phase. The result sits in an output register: if the
// receiver stalls, new samples are still taken, and only the next series
// result waits until the pending one is taken. Reset clears all series
// state, sets the lag register to 2 and needs no clearing pass.
`default_nettype none

`include "parzen_hac_variance_assert.svh"

module parzen_hac_variance #(
  parameter int MAX_LAG     = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [phv_pkg::LAG_BITS-1:0]  cfg_wdata_i,
  // sample channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [phv_pkg::WORD_BITS-1:0] sample_i,
  input  wire logic                          last_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [phv_pkg::ACC_BITS-1:0]       variance_o,
  output logic                               too_few_o,
  output logic                               saturated_o
);
  import phv_pkg::*;

  localparam int PROD_BITS = 2 * SAMPLE_BITS;
  localparam int LAG_CLAMP = (MAX_LAG > 127) ? 127 : MAX_LAG;
  localparam logic [LAG_BITS-1:0] LAG_LIM = LAG_BITS'(LAG_CLAMP);

  top_state_e state_q, state_d;

  logic [LAG_BITS-1:0]         lag_q;
  logic [LAG_BITS-1:0]         lag_eff;
  logic                        in_fire;
  logic                        s2_valid_q;
  logic signed [PROD_BITS-1:0] sq_prod_q;
  logic [ACC_BITS-1:0]         sq_sum_q;
  logic [CNT_BITS-1:0]         cnt_q;
  logic                        ovf_q;
  logic [LAG_BITS-1:0]         k_q;
  logic                        neg_q;
  logic [62:0]                 hp_q;
  logic [62:0]                 lp_q;
  logic [ACC_BITS-1:0]         term_q;
  logic                        term_ovf_q;
  logic [ACC_BITS-1:0]         wsum_q;
  logic [ACC_BITS-1:0]         res_q;
  logic                        too_few_q;
  logic                        out_valid_q;
  logic [ACC_BITS-1:0]         variance_q;
  logic                        too_few_out_q;
  logic                        saturated_q;

  logic                        too_few_w;
  logic                        short_w;
  logic                        last_k_w;
  logic                        res_load;
  logic                        wgt_start;
  logic                        wgt_done;
  logic [WQ_BITS-1:0]          wq_w;
  cell_ctl_t                   cell_ctl;

  logic signed [SAMPLE_BITS-1:0] x_w;
  logic signed [ACC_BITS-1:0]    sq_ext;
  sat_res_t                      sq_add;
  sat_res_t                      wsum_add;
  sat_res_t                      dbl_add;
  sat_res_t                      fin_add;
  logic                          any_cell_ovf;

  logic [ACC_BITS-1:0]   head_acc;
  logic [ACC_BITS-1:0]   mag_w;
  logic [ACC_BITS-1:0]   lo_sum;
  logic [ACC_BITS:0]     p_w;
  logic [ACC_BITS-1:0]   term_d;
  logic                  term_ovf_d;

  logic signed [SAMPLE_BITS-1:0] dly_w [MAX_LAG];
  logic [ACC_BITS-1:0]           acc_w [MAX_LAG+1];
  logic [MAX_LAG-1:0]            cell_ovf;

  assign x_w       = sample_i[SAMPLE_BITS-1:0];
  assign lag_eff   = (lag_q > LAG_LIM) ? LAG_LIM : lag_q;
  assign too_few_w = cnt_q <= CNT_BITS'(lag_eff);
  assign short_w   = too_few_w || (lag_eff <= LAG_BITS'(1));
  assign last_k_w  = k_q == lag_eff;
  assign in_fire   = in_valid_i & in_ready_o;

  // lag register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lag_q <= LAG_BITS'(2);
    end else if (cfg_we_i) begin
      lag_q <= cfg_wdata_i;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN:    if (in_fire && last_i) state_d = ST_SETTLE;
      ST_SETTLE: state_d = ST_CHECK;
      ST_CHECK:  state_d = short_w ? ST_DONE : ST_WSTART;
      ST_WSTART: state_d = ST_WWAIT;
      ST_WWAIT:  if (wgt_done) state_d = ST_MUL;
      ST_MUL:    state_d = ST_TERM;
      ST_TERM:   state_d = ST_ACC;
      ST_ACC:    state_d = last_k_w ? ST_DBL : ST_WSTART;
      ST_DBL:    state_d = ST_SUM;
      ST_SUM:    state_d = ST_DONE;
      ST_DONE:   if (!out_valid_q || out_ready_i) state_d = ST_RUN;
      default:   state_d = ST_RUN;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o     = 1'b0;
    wgt_start      = 1'b0;
    res_load       = 1'b0;
    cell_ctl.drain = 1'b0;
    case (state_q)
      ST_RUN:    in_ready_o = 1'b1;
      ST_WSTART: wgt_start = 1'b1;
      ST_ACC:    cell_ctl.drain = 1'b1;
      ST_DONE:   res_load = !out_valid_q || out_ready_i;
      default: begin
      end
    endcase
    cell_ctl.load  = in_fire;
    cell_ctl.add   = s2_valid_q;
    cell_ctl.clear = res_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  // row of lag cells: taps shift away from the head, sums drain toward it
  assign acc_w[MAX_LAG] = '0;

  for (genvar g = 0; g < MAX_LAG; g++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] tap_in;
    if (g == 0) begin : g_head
      assign tap_in = x_w;
    end else begin : g_body
      assign tap_in = dly_w[g-1];
    end
    phv_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (cell_ctl),
      .x_i   (x_w),
      .dly_i (tap_in),
      .dly_o (dly_w[g]),
      .acc_i (acc_w[g+1]),
      .acc_o (acc_w[g]),
      .ovf_o (cell_ovf[g])
    );
  end

  assign any_cell_ovf = |cell_ovf;
  assign head_acc     = acc_w[0];

  // parzen weight unit
  phv_weight u_weight (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(wgt_start),
    .lag_i  (lag_eff),
    .k_i    (k_q),
    .done_o (wgt_done),
    .wq_o   (wq_w)
  );

  // sum of squares and sample count
  assign sq_ext = ACC_BITS'(sq_prod_q);
  assign sq_add = sat_add(sq_sum_q, sq_ext);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sq_prod_q <= PROD_BITS'(x_w) * PROD_BITS'(x_w);
    end
  end

  // term scaling: |acc| * wq / 2^30, rounded half away from zero
  assign mag_w  = head_acc[ACC_BITS-1] ? (ACC_BITS'(0) - head_acc) : head_acc;
  assign lo_sum = {1'b0, lp_q} + (ACC_BITS'(1) << (FRAC_BITS - 1));
  assign p_w    = {hp_q, 2'b00} + (ACC_BITS+1)'(lo_sum[ACC_BITS-1:FRAC_BITS]);

  always_comb begin
    term_ovf_d = 1'b0;
    if (neg_q) begin
      if (p_w > ((ACC_BITS+1)'(1) << (ACC_BITS - 1))) begin
        term_ovf_d = 1'b1;
        term_d     = ACC_MIN;
      end else begin
        term_d = ACC_BITS'(0) - p_w[ACC_BITS-1:0];
      end
    end else begin
      if (p_w >= ((ACC_BITS+1)'(1) << (ACC_BITS - 1))) begin
        term_ovf_d = 1'b1;
        term_d     = ACC_MAX;
      end else begin
        term_d = p_w[ACC_BITS-1:0];
      end
    end
  end

  assign wsum_add = sat_add(wsum_q, term_q);
  assign dbl_add  = sat_add(wsum_q, wsum_q);
  assign fin_add  = sat_add(sq_sum_q, wsum_q);

  // weighting datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_CHECK: begin
        too_few_q <= too_few_w;
        wsum_q    <= '0;
        res_q     <= too_few_w ? '0 : sq_sum_q;
      end
      ST_MUL: begin
        neg_q <= head_acc[ACC_BITS-1];
        hp_q  <= 63'(mag_w[ACC_BITS-1:32]) * 63'(wq_w);
        lp_q  <= 63'(mag_w[31:0]) * 63'(wq_w);
      end
      ST_TERM: begin
        term_q     <= term_d;
        term_ovf_q <= term_ovf_d;
      end
      ST_ACC:  wsum_q <= wsum_add.val;
      ST_DBL:  wsum_q <= dbl_add.val;
      ST_SUM:  res_q  <= fin_add.val;
      default: begin
      end
    endcase
  end

  // series state and term index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      sq_sum_q   <= '0;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      k_q        <= '0;
    end else if (res_load) begin
      s2_valid_q <= 1'b0;
      sq_sum_q   <= '0;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
    end else begin
      s2_valid_q <= in_fire;
      if (in_fire && (cnt_q != '1)) begin
        cnt_q <= cnt_q + CNT_BITS'(1);
      end
      if (s2_valid_q) begin
        sq_sum_q <= sq_add.val;
        ovf_q    <= ovf_q | sq_add.ovf | any_cell_ovf;
      end
      case (state_q)
        ST_CHECK: k_q <= LAG_BITS'(1);
        ST_ACC: begin
          k_q   <= k_q + LAG_BITS'(1);
          ovf_q <= ovf_q | term_ovf_q | wsum_add.ovf;
        end
        ST_DBL:  ovf_q <= ovf_q | dbl_add.ovf;
        ST_SUM:  ovf_q <= ovf_q | fin_add.ovf;
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      variance_q    <= res_q;
      too_few_out_q <= too_few_q;
      saturated_q   <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign variance_o  = variance_q;
  assign too_few_o   = too_few_out_q;
  assign saturated_o = saturated_q;

  // checks
  `PHV_ASSERT_IMP(a_result_from_done, clk_i, rst_ni, $rose(out_valid_o), $past(state_q == ST_DONE), "result word raised outside the done step")
  `PHV_ASSERT_IMP(a_term_in_range, clk_i, rst_ni, state_q == ST_ACC, (k_q != '0) && (k_q <= lag_eff), "term index outside 1..L")
  `PHV_ASSERT_NXT(a_series_cleared, clk_i, rst_ni, res_load, (cnt_q == '0) && (sq_sum_q == '0) && !ovf_q, "series state not cleared after result")
  `PHV_ASSERT_IMP(a_weight_bound, clk_i, rst_ni, wgt_done, (wq_w <= WQ_ONE) && (state_q == ST_WWAIT), "weight above one or not awaited")

endmodule

`default_nettype wire

// ===== rtl/core/phv_cell.sv =====
`default_nettype none

module phv_cell #(
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire phv_pkg::cell_ctl_t            ctl_i,
  input  wire logic signed [SAMPLE_BITS-1:0] x_i,
  input  wire logic signed [SAMPLE_BITS-1:0] dly_i,
  output logic signed [SAMPLE_BITS-1:0]      dly_o,
  input  wire logic [phv_pkg::ACC_BITS-1:0]  acc_i,
  output logic [phv_pkg::ACC_BITS-1:0]       acc_o,
  output logic                               ovf_o
);
  import phv_pkg::*;

  localparam int PROD_BITS = 2 * SAMPLE_BITS;

  logic signed [SAMPLE_BITS-1:0] dly_q;
  logic signed [PROD_BITS-1:0]   prod_q;
  logic [ACC_BITS-1:0]           acc_q;
  logic signed [ACC_BITS-1:0]    prod_ext;
  sat_res_t                      add_res;

  // product with the word held here, before the line shifts
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      prod_q <= PROD_BITS'(x_i) * PROD_BITS'(dly_q);
    end
  end

  assign prod_ext = ACC_BITS'(prod_q);
  assign add_res  = sat_add(acc_q, prod_ext);

  // delay tap and lag accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_q <= '0;
      acc_q <= '0;
    end else if (ctl_i.clear) begin
      dly_q <= '0;
      acc_q <= '0;
    end else begin
      if (ctl_i.load) begin
        dly_q <= dly_i;
      end
      if (ctl_i.drain) begin
        acc_q <= acc_i;
      end else if (ctl_i.add) begin
        acc_q <= add_res.val;
      end
    end
  end

  assign dly_o = dly_q;
  assign acc_o = acc_q;
  assign ovf_o = ctl_i.add & add_res.ovf;

endmodule

`default_nettype wire

// ===== rtl/core/phv_weight.sv =====
`default_nettype none

module phv_weight (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [phv_pkg::LAG_BITS-1:0] lag_i,
  input  wire logic [phv_pkg::LAG_BITS-1:0] k_i,
  output logic                              done_o,
  output logic [phv_pkg::WQ_BITS-1:0]       wq_o
);
  import phv_pkg::*;

  localparam int DIVIDEND_BITS = NUM_BITS + FRAC_BITS;

  wgt_state_e state_q, state_d;

  logic [LAG_BITS-1:0]     lag_q;
  logic [LAG_BITS-1:0]     base_q;
  logic                    upper_q;
  logic [SQ_BITS-1:0]      sq_q;
  logic [SQ_BITS-1:0]      l2_q;
  logic [CUBE_BITS-1:0]    cube_q;
  logic [CUBE_BITS-1:0]    ksql_q;
  logic [CUBE_BITS-1:0]    l3_q;
  logic [CUBE_BITS-1:0]    rem_q;
  logic [WQ_BITS-1:0]      nlow_q;
  logic [WQ_BITS-1:0]      quo_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;

  logic [NUM_BITS+2:0]      num_full;
  logic [NUM_BITS-1:0]      num_w;
  logic [DIVIDEND_BITS-1:0] dividend;
  logic [CUBE_BITS:0]       rem_shift;
  logic                     rem_ge;
  logic                     upper_w;

  // lower half uses k, upper half uses L - k
  assign upper_w = k_i > (lag_i >> 1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      WS_IDLE: if (start_i) state_d = WS_SQ;
      WS_SQ:   state_d = WS_CUBE;
      WS_CUBE: state_d = WS_NUM;
      WS_NUM:  state_d = WS_DIV;
      WS_DIV:  if (cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1)) state_d = WS_DONE;
      WS_DONE: state_d = WS_IDLE;
      default: state_d = WS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done_o = 1'b0;
    case (state_q)
      WS_DONE: done_o = 1'b1;
      default: done_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= WS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // kernel numerator: L^3 - 6k^2 L + 6k^3 or 2(L-k)^3
  assign num_full = (NUM_BITS+3)'(l3_q) + (NUM_BITS+3)'(cube_q) * (NUM_BITS+3)'(6)
                  - (NUM_BITS+3)'(ksql_q) * (NUM_BITS+3)'(6);
  assign num_w    = upper_q ? {cube_q, 1'b0} : num_full[NUM_BITS-1:0];
  assign dividend = {num_w, {FRAC_BITS{1'b0}}} + DIVIDEND_BITS'(l3_q >> 1);

  // restoring division step
  assign rem_shift = {rem_q, nlow_q[WQ_BITS-1]};
  assign rem_ge    = rem_shift >= {1'b0, l3_q};

  always_ff @(posedge clk_i) begin
    case (state_q)
      WS_IDLE: begin
        if (start_i) begin
          lag_q   <= lag_i;
          upper_q <= upper_w;
          base_q  <= upper_w ? (lag_i - k_i) : k_i;
        end
      end
      WS_SQ: begin
        sq_q <= SQ_BITS'(base_q) * SQ_BITS'(base_q);
        l2_q <= SQ_BITS'(lag_q) * SQ_BITS'(lag_q);
      end
      WS_CUBE: begin
        cube_q <= CUBE_BITS'(sq_q) * CUBE_BITS'(base_q);
        ksql_q <= CUBE_BITS'(sq_q) * CUBE_BITS'(lag_q);
        l3_q   <= CUBE_BITS'(l2_q) * CUBE_BITS'(lag_q);
      end
      WS_NUM: begin
        rem_q  <= dividend[DIVIDEND_BITS-1:WQ_BITS];
        nlow_q <= dividend[WQ_BITS-1:0];
        quo_q  <= '0;
        cnt_q  <= '0;
      end
      WS_DIV: begin
        rem_q  <= rem_ge ? CUBE_BITS'(rem_shift - {1'b0, l3_q}) : CUBE_BITS'(rem_shift);
        nlow_q <= {nlow_q[WQ_BITS-2:0], 1'b0};
        quo_q  <= {quo_q[WQ_BITS-2:0], rem_ge};
        cnt_q  <= cnt_q + DIV_CNT_BITS'(1);
      end
      default: begin
      end
    endcase
  end

  assign wq_o = quo_q;

endmodule

`default_nettype wire
